// ===== hw/rtl/icpne_pkg.sv =====
// ----------------------------------------------------------------------------
// ICP normal-equation accumulator package
// Shared types, constants and the Jacobian column tables.
// ----------------------------------------------------------------------------
package icpne_pkg;

  localparam int unsigned NumEntries = 27;
  localparam logic [4:0]  LastEntry  = 5'd26;
  localparam logic [4:0]  FirstRhs   = 5'd21;
  localparam logic [31:0] KernelReset = 32'h0001_0000;
  localparam logic [2:0]  ColR       = 3'd6;

  typedef enum logic [1:0] {
    ES_ZERO = 2'd0,
    ES_ONE  = 2'd1,
    ES_S    = 2'd2,
    ES_R    = 2'd3
  } esrc_t;

  typedef struct packed {
    esrc_t      src;
    logic [1:0] axis;
    logic       neg;
  } elem_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
  } pair_t;

  typedef struct packed {
    logic            has_pair;
    logic            last;
    logic [2:0]      s_neg;
    logic [2:0][31:0] s_mag;
    logic [2:0]      r_neg;
    logic [2:0][31:0] r_mag;
  } item_t;

  function automatic elem_t col_elem(input logic [2:0] col, input logic [1:0] row);
    elem_t e;
    e = '{src: ES_ZERO, axis: 2'd0, neg: 1'b0};
    unique case (col)
      3'd0, 3'd1, 3'd2: begin
        if (row == col[1:0]) e.src = ES_ONE;
      end
      3'd3: begin
        if (row == 2'd1) e = '{src: ES_S, axis: 2'd2, neg: 1'b1};
        if (row == 2'd2) e = '{src: ES_S, axis: 2'd1, neg: 1'b0};
      end
      3'd4: begin
        if (row == 2'd0) e = '{src: ES_S, axis: 2'd2, neg: 1'b0};
        if (row == 2'd2) e = '{src: ES_S, axis: 2'd0, neg: 1'b1};
      end
      3'd5: begin
        if (row == 2'd0) e = '{src: ES_S, axis: 2'd1, neg: 1'b1};
        if (row == 2'd1) e = '{src: ES_S, axis: 2'd0, neg: 1'b0};
      end
      3'd6: begin
        e = '{src: ES_R, axis: row, neg: 1'b0};
      end
      default: e = '{src: ES_ZERO, axis: 2'd0, neg: 1'b0};
    endcase
    return e;
  endfunction

  function automatic pair_t entry_cols(input logic [4:0] idx);
    pair_t p;
    unique case (idx)
      5'd0:  p = '{a: 3'd0, b: 3'd0};
      5'd1:  p = '{a: 3'd0, b: 3'd1};
      5'd2:  p = '{a: 3'd0, b: 3'd2};
      5'd3:  p = '{a: 3'd0, b: 3'd3};
      5'd4:  p = '{a: 3'd0, b: 3'd4};
      5'd5:  p = '{a: 3'd0, b: 3'd5};
      5'd6:  p = '{a: 3'd1, b: 3'd1};
      5'd7:  p = '{a: 3'd1, b: 3'd2};
      5'd8:  p = '{a: 3'd1, b: 3'd3};
      5'd9:  p = '{a: 3'd1, b: 3'd4};
      5'd10: p = '{a: 3'd1, b: 3'd5};
      5'd11: p = '{a: 3'd2, b: 3'd2};
      5'd12: p = '{a: 3'd2, b: 3'd3};
      5'd13: p = '{a: 3'd2, b: 3'd4};
      5'd14: p = '{a: 3'd2, b: 3'd5};
      5'd15: p = '{a: 3'd3, b: 3'd3};
      5'd16: p = '{a: 3'd3, b: 3'd4};
      5'd17: p = '{a: 3'd3, b: 3'd5};
      5'd18: p = '{a: 3'd4, b: 3'd4};
      5'd19: p = '{a: 3'd4, b: 3'd5};
      5'd20: p = '{a: 3'd5, b: 3'd5};
      5'd21: p = '{a: 3'd0, b: ColR};
      5'd22: p = '{a: 3'd1, b: ColR};
      5'd23: p = '{a: 3'd2, b: ColR};
      5'd24: p = '{a: 3'd3, b: ColR};
      5'd25: p = '{a: 3'd4, b: ColR};
      5'd26: p = '{a: 3'd5, b: ColR};
      default: p = '{a: 3'd0, b: 3'd0};
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/icp_normal_equation_accumulator.sv =====
// ----------------------------------------------------------------------------
// ICP normal-equation accumulator
// Accumulates weighted point-to-point Gauss-Newton normal equations.
// ----------------------------------------------------------------------------
// Per point pair, unless the kernel is zero, the weight takes three squares
// and, unless the squared residual is zero, a 32-step radix-2 divide and one
// square; the 27 entries follow, all on one shared 32x32 multiplier. A flush
// streams out the sums. A request with neither pair nor last flag is dropped.
// Reset (rst_n low, synchronous) clears all sums and marks, sets the kernel
// to 1.0, and empties the queue; no clearing pass follows.
module icp_normal_equation_accumulator import icpne_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_has_pair,
  input  logic [31:0] in_src_x,
  input  logic [31:0] in_src_y,
  input  logic [31:0] in_src_z,
  input  logic [31:0] in_tgt_x,
  input  logic [31:0] in_tgt_y,
  input  logic [31:0] in_tgt_z,
  input  logic        in_last_pair,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_entry_index,
  output logic [63:0] out_entry_value,
  output logic        out_entry_saturated,
  output logic        out_last_entry
);

  logic [31:0] kernel_r;
  logic        q_full;
  logic        q_push;
  item_t       q_item;
  logic        q_pop;
  logic        head_valid;
  item_t       head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KernelReset;
    end else if (cfg_wr_en) begin
      kernel_r <= cfg_wr_data;
    end
  end

  icpne_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_has_pair  (in_has_pair),
    .in_src_x     (in_src_x),
    .in_src_y     (in_src_y),
    .in_src_z     (in_src_z),
    .in_tgt_x     (in_tgt_x),
    .in_tgt_y     (in_tgt_y),
    .in_tgt_z     (in_tgt_z),
    .in_last_pair (in_last_pair),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  icpne_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  icpne_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .kernel              (kernel_r),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_entry_index     (out_entry_index),
    .out_entry_value     (out_entry_value),
    .out_entry_saturated (out_entry_saturated),
    .out_last_entry      (out_last_entry)
  );

endmodule

// ===== hw/rtl/icpne_front.sv =====
// ----------------------------------------------------------------------------
// ICP accumulator front end
// Accepts requests, drops empty ones and forms residual magnitudes and signs.
// ----------------------------------------------------------------------------
module icpne_front import icpne_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_has_pair,
  input  logic [31:0] in_src_x,
  input  logic [31:0] in_src_y,
  input  logic [31:0] in_src_z,
  input  logic [31:0] in_tgt_x,
  input  logic [31:0] in_tgt_y,
  input  logic [31:0] in_tgt_z,
  input  logic        in_last_pair,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic [2:0][31:0] src;
  logic [2:0][31:0] tgt;
  logic [32:0]      diff [3];

  assign src = {in_src_z, in_src_y, in_src_x};
  assign tgt = {in_tgt_z, in_tgt_y, in_tgt_x};

  always_comb begin
    q_item.has_pair = in_has_pair;
    q_item.last     = in_last_pair;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {src[i][31], src[i]} - {tgt[i][31], tgt[i]};
      q_item.s_neg[i] = src[i][31];
      q_item.s_mag[i] = src[i][31] ? (32'd0 - src[i]) : src[i];
      q_item.r_neg[i] = diff[i][32];
      q_item.r_mag[i] = diff[i][32] ? 32'(33'd0 - diff[i]) : diff[i][31:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_has_pair || in_last_pair);

endmodule

// ===== hw/rtl/icpne_queue.sv =====
// ----------------------------------------------------------------------------
// ICP accumulator request queue
// Two-entry queue between the front end and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module icpne_queue import icpne_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/icpne_back.sv =====
// ----------------------------------------------------------------------------
// ICP accumulator sequencer
// Computes the robust weight and the 27 weighted increments with one shared
// multiplier and a radix-2 divider, and streams out the sums on a flush.
// ----------------------------------------------------------------------------
module icpne_back import icpne_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] kernel,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_entry_index,
  output logic [63:0] out_entry_value,
  output logic        out_entry_saturated,
  output logic        out_last_entry
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_SQ_MUL = 14'b00000000000010,
    ST_SQ_ADD = 14'b00000000000100,
    ST_DIV    = 14'b00000000001000,
    ST_QQ_MUL = 14'b00000000010000,
    ST_QQ_USE = 14'b00000000100000,
    ST_T_MUL  = 14'b00000001000000,
    ST_T_ADD  = 14'b00000010000000,
    ST_DIFF   = 14'b00000100000000,
    ST_H_MUL  = 14'b00001000000000,
    ST_H_USE  = 14'b00010000000000,
    ST_L_MUL  = 14'b00100000000000,
    ST_ACC    = 14'b01000000000000,
    ST_EMIT   = 14'b10000000000000
  } state_t;

  localparam logic [31:0] OneFix = 32'd1 << COORD_FRAC_BITS;

  state_t     state_r;
  item_t      item_r;
  logic [1:0] cnt_r;
  logic [4:0] div_cnt_r;
  logic [4:0] ent_r;
  logic [63:0] prod_r;
  logic [63:0] sq_r;
  logic [32:0] rem_r;
  logic [32:0] d_r;
  logic [31:0] q_r;
  logic [31:0] w_r;
  logic [63:0] pos_r;
  logic [63:0] neg_r;
  logic        tneg_r;
  logic [63:0] m_r;
  logic        mneg_r;
  logic [63:0] hi_r;
  logic [63:0] sum_r [NumEntries];
  logic [NumEntries-1:0] sat_r;
  logic        out_valid_r;
  logic [4:0]  out_entry_index_r;
  logic [63:0] out_entry_value_r;
  logic        out_entry_saturated_r;
  logic        out_last_entry_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  pair_t       pair;
  elem_t       ea;
  elem_t       eb;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        sgn_a;
  logic        sgn_b;
  logic [64:0] sq_sum;
  logic [63:0] sq_nxt;
  logic [63:0] sq_sh;
  logic [31:0] r2;
  logic [33:0] div_t;
  logic        div_ge;
  logic [63:0] t_mag;
  logic signed [64:0] incr;
  logic signed [64:0] acc_sum;
  logic        emit_load;

  function automatic logic [31:0] elem_mag(input elem_t e, input item_t it,
                                           input logic [31:0] one);
    logic [31:0] m;
    unique case (e.src)
      ES_ZERO: m = 32'd0;
      ES_ONE:  m = one;
      ES_S:    m = it.s_mag[e.axis];
      ES_R:    m = it.r_mag[e.axis];
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic elem_sgn(input elem_t e, input item_t it);
    logic s;
    unique case (e.src)
      ES_S:    s = it.s_neg[e.axis] ^ e.neg;
      ES_R:    s = it.r_neg[e.axis];
      default: s = 1'b0;
    endcase
    return s;
  endfunction

  always_comb begin
    pair  = entry_cols(ent_r);
    ea    = col_elem(pair.a, cnt_r);
    eb    = col_elem(pair.b, cnt_r);
    mag_a = elem_mag(ea, item_r, OneFix);
    mag_b = elem_mag(eb, item_r, OneFix);
    sgn_a = elem_sgn(ea, item_r);
    sgn_b = elem_sgn(eb, item_r);
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      ST_SQ_MUL: begin
        mul_a = item_r.r_mag[cnt_r];
        mul_b = item_r.r_mag[cnt_r];
      end
      ST_QQ_MUL: begin
        mul_a = q_r;
        mul_b = q_r;
      end
      ST_T_MUL: begin
        mul_a = mag_a;
        mul_b = mag_b;
      end
      ST_H_MUL: begin
        mul_a = m_r[63:32];
        mul_b = w_r;
      end
      ST_L_MUL: begin
        mul_a = m_r[31:0];
        mul_b = w_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    sq_sum  = {1'b0, sq_r} + {1'b0, prod_r};
    sq_nxt  = sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
    sq_sh   = sq_nxt >> COORD_FRAC_BITS;
    r2      = (|sq_sh[63:32]) ? 32'hFFFF_FFFF : sq_sh[31:0];
    div_t   = {rem_r, 1'b0};
    div_ge  = (div_t >= {1'b0, d_r});
    t_mag   = (hi_r + {32'd0, prod_r[63:32]}) >> COORD_FRAC_BITS;
    incr    = mneg_r ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
    acc_sum = $signed({sum_r[ent_r][63], sum_r[ent_r]}) + incr;
  end

  assign pop       = (state_r == ST_IDLE) && head_valid;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sat_r       <= '0;
      for (int i = 0; i < NumEntries; i++) begin
        sum_r[i] <= 64'd0;
      end
    end else begin
      if (out_valid_r && !out_stall && !emit_load) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          pos_r <= 64'd0;
          neg_r <= 64'd0;
          cnt_r <= 2'd0;
          ent_r <= 5'd0;
          sq_r  <= 64'd0;
          if (head_valid) begin
            item_r <= head_item;
            if (head_item.has_pair && kernel != 32'd0) begin
              state_r <= ST_SQ_MUL;
            end else if (head_item.last) begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_SQ_MUL: state_r <= ST_SQ_ADD;
        ST_SQ_ADD: begin
          sq_r <= sq_nxt;
          if (cnt_r != 2'd2) begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= ST_SQ_MUL;
          end else begin
            cnt_r <= 2'd0;
            if (r2 == 32'd0) begin
              w_r     <= 32'hFFFF_FFFF;
              state_r <= ST_T_MUL;
            end else begin
              d_r       <= {1'b0, kernel} + {1'b0, r2};
              rem_r     <= {1'b0, kernel};
              div_cnt_r <= 5'd0;
              state_r   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_r     <= div_ge ? 33'(div_t - {1'b0, d_r}) : div_t[32:0];
          q_r       <= {q_r[30:0], div_ge};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) state_r <= ST_QQ_MUL;
        end
        ST_QQ_MUL: state_r <= ST_QQ_USE;
        ST_QQ_USE: begin
          w_r     <= prod_r[63:32];
          state_r <= ST_T_MUL;
        end
        ST_T_MUL: begin
          tneg_r  <= sgn_a ^ sgn_b;
          state_r <= ST_T_ADD;
        end
        ST_T_ADD: begin
          if (tneg_r) neg_r <= neg_r + prod_r;
          else pos_r <= pos_r + prod_r;
          if (cnt_r == 2'd2) begin
            state_r <= ST_DIFF;
          end else begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= ST_T_MUL;
          end
        end
        ST_DIFF: begin
          mneg_r  <= (neg_r > pos_r);
          m_r     <= (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
          state_r <= ST_H_MUL;
        end
        ST_H_MUL: state_r <= ST_H_USE;
        ST_H_USE: begin
          hi_r    <= prod_r;
          state_r <= ST_L_MUL;
        end
        ST_L_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          if (acc_sum[64] != acc_sum[63]) begin
            sum_r[ent_r] <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            sat_r[ent_r] <= 1'b1;
          end else begin
            sum_r[ent_r] <= acc_sum[63:0];
          end
          pos_r <= 64'd0;
          neg_r <= 64'd0;
          cnt_r <= 2'd0;
          if (ent_r == LastEntry) begin
            ent_r   <= 5'd0;
            state_r <= item_r.last ? ST_EMIT : ST_IDLE;
          end else begin
            ent_r   <= ent_r + 5'd1;
            state_r <= ST_T_MUL;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_r           <= 1'b1;
            out_entry_index_r     <= ent_r;
            out_entry_value_r     <= sum_r[ent_r];
            out_entry_saturated_r <= sat_r[ent_r];
            out_last_entry_r      <= (ent_r == LastEntry);
            sum_r[ent_r]          <= 64'd0;
            sat_r[ent_r]          <= 1'b0;
            ent_r                 <= (ent_r == LastEntry) ? 5'd0 : ent_r + 5'd1;
            if (ent_r == LastEntry) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_entry_index     = out_entry_index_r;
  assign out_entry_value     = out_entry_value_r;
  assign out_entry_saturated = out_entry_saturated_r;
  assign out_last_entry      = out_last_entry_r;

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_entry_r) |-> (out_entry_index_r == LastEntry))
    else $error("Last entry flag on a non-final index.");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && ent_r == LastEntry) |=> (state_r == ST_IDLE && out_last_entry_r))
    else $error("Emission did not end after the final entry.");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("Divider remainder not below divisor.");

  a_acc_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC || state_r == ST_EMIT) |-> (ent_r <= LastEntry))
    else $error("Entry index out of range.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICP normal-equation accumulator testbench
// Streams point pairs through the accumulator with bursty requests and a
// stalling receiver, predicts the 27 normal-equation sums of every set, and
// compares each emitted entry field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import icpne_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic        has_pair;
    logic [31:0] sx, sy, sz, tx, ty, tz;
    logic        last;
  } pair_req_t;

  typedef struct packed {
    logic [4:0]  index;
    logic [63:0] value;
    logic        saturated;
    logic        last_entry;
  } entry_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic in_has_pair, in_last_pair;
  logic [31:0] in_src_x, in_src_y, in_src_z, in_tgt_x, in_tgt_y, in_tgt_z;
  logic [4:0] out_entry_index;
  logic [63:0] out_entry_value;
  logic out_entry_saturated, out_last_entry;

  icp_normal_equation_accumulator #(.COORD_FRAC_BITS(FracBits)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_has_pair(in_has_pair),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_src_z(in_src_z),
    .in_tgt_x(in_tgt_x), .in_tgt_y(in_tgt_y), .in_tgt_z(in_tgt_z),
    .in_last_pair(in_last_pair),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_index(out_entry_index), .out_entry_value(out_entry_value),
    .out_entry_saturated(out_entry_saturated), .out_last_entry(out_last_entry)
  );

  pair_req_t pending_reqs[$];
  entry_t expected_entries[$];
  logic [31:0] kernel;
  logic signed [63:0] sums [NumEntries];
  logic sat_marks [NumEntries];
  int errors = 0;
  int sets_done = 0;
  int pairs_done = 0;
  int entries_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] mag_of(input logic signed [63:0] v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [31:0] pair_weight(input logic signed [63:0] r [3]);
    logic [127:0] sq;
    logic [63:0] r2, q;
    sq = 0;
    if (kernel == 0) return 32'd0;
    for (int i = 0; i < 3; i++) sq += mag_of(r[i]) * mag_of(r[i]);
    if (sq > 128'hFFFF_FFFF_FFFF_FFFF) sq = 128'hFFFF_FFFF_FFFF_FFFF;
    r2 = sq[63:0] >> FracBits;
    if (r2 > 64'hFFFF_FFFF) r2 = 64'hFFFF_FFFF;
    q = ({32'd0, kernel} << 32) / ({32'd0, kernel} + r2);
    if (q >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
    return 32'((q * q) >> 32);
  endfunction

  function automatic logic signed [63:0] weighted_dot(
      input logic signed [63:0] a [3], input logic signed [63:0] b [3],
      input logic [31:0] w);
    logic [127:0] pos, neg, m, t;
    logic [127:0] p;
    logic negative;
    pos = 0;
    neg = 0;
    for (int i = 0; i < 3; i++) begin
      p = mag_of(a[i]) * mag_of(b[i]);
      if ((a[i] < 0) != (b[i] < 0)) neg = 64'(neg + p);
      else pos = 64'(pos + p);
    end
    negative = neg > pos;
    m = negative ? neg - pos : pos - neg;
    t = (({64'd0, m[63:32]} * w) + ((m[31:0] * w) >> 32)) >> FracBits;
    return negative ? -$signed(t[63:0]) : $signed(t[63:0]);
  endfunction

  task automatic add_clipped(input int idx, input logic signed [63:0] inc);
    logic signed [64:0] total;
    total = 65'(sums[idx]) + 65'(inc);
    if (total > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sums[idx] = 64'sh7FFF_FFFF_FFFF_FFFF;
      sat_marks[idx] = 1'b1;
    end else if (total < -65'sh0_8000_0000_0000_0000) begin
      sums[idx] = 64'sh8000_0000_0000_0000;
      sat_marks[idx] = 1'b1;
    end else begin
      sums[idx] = total[63:0];
    end
  endtask

  task automatic predict_normal_equations(input pair_req_t req);
    logic signed [63:0] s [3], r [3], cols [7][3];
    logic [31:0] w;
    int idx;
    if (req.has_pair) begin
      s[0] = $signed(req.sx);
      s[1] = $signed(req.sy);
      s[2] = $signed(req.sz);
      r[0] = s[0] - $signed(req.tx);
      r[1] = s[1] - $signed(req.ty);
      r[2] = s[2] - $signed(req.tz);
      w = pair_weight(r);
      for (int c = 0; c < 6; c++)
        for (int i = 0; i < 3; i++) cols[c][i] = 0;
      for (int i = 0; i < 3; i++) cols[i][i] = 64'sd1 << FracBits;
      cols[3][1] = -s[2];
      cols[3][2] = s[1];
      cols[4][0] = s[2];
      cols[4][2] = -s[0];
      cols[5][0] = -s[1];
      cols[5][1] = s[0];
      idx = 0;
      for (int a = 0; a < 6; a++)
        for (int b = a; b < 6; b++) begin
          add_clipped(idx, weighted_dot(cols[a], cols[b], w));
          idx++;
        end
      for (int a = 0; a < 6; a++) begin
        add_clipped(idx, weighted_dot(cols[a], r, w));
        idx++;
      end
      pairs_done++;
    end
    if (req.last) begin
      for (int k = 0; k < NumEntries; k++) begin
        expected_entries.push_back('{index: 5'(k), value: sums[k],
                                     saturated: sat_marks[k],
                                     last_entry: (5'(k) == LastEntry)});
        sums[k] = 0;
        sat_marks[k] = 1'b0;
      end
      sets_done++;
    end
  endtask

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_normal_equations(pending_reqs.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        pair_req_t nxt;
        nxt = pending_reqs[0];
        in_valid <= 1'b1;
        in_has_pair <= nxt.has_pair;
        in_src_x <= nxt.sx;
        in_src_y <= nxt.sy;
        in_src_z <= nxt.sz;
        in_tgt_x <= nxt.tx;
        in_tgt_y <= nxt.ty;
        in_tgt_z <= nxt.tz;
        in_last_pair <= nxt.last;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        entry_t got, exp_e;
        got = '{index: out_entry_index, value: out_entry_value,
                saturated: out_entry_saturated, last_entry: out_last_entry};
        entries_seen++;
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected entry %0d value %h", $time, got.index, got.value);
          errors++;
        end else begin
          exp_e = expected_entries.pop_front();
          if (got.index !== exp_e.index) begin
            $display("%0t: index exp %0d got %0d", $time, exp_e.index, got.index);
            errors++;
          end
          if (got.value !== exp_e.value) begin
            $display("%0t: entry %0d value exp %h got %h", $time, exp_e.index,
                     exp_e.value, got.value);
            errors++;
          end
          if (got.saturated !== exp_e.saturated) begin
            $display("%0t: entry %0d saturated exp %b got %b", $time, exp_e.index,
                     exp_e.saturated, got.saturated);
            errors++;
          end
          if (got.last_entry !== exp_e.last_entry) begin
            $display("%0t: entry %0d last exp %b got %b", $time, exp_e.index,
                     exp_e.last_entry, got.last_entry);
            errors++;
          end
        end
      end
      if (($time / 2000) % 3 == 2) out_stall <= 1'b0;
      else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // Watchdog on cycles without any accepted request or entry.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord(input int span);
    case (span)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  function automatic pair_req_t random_pair(input logic last);
    pair_req_t p;
    int span;
    span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
    p.has_pair = 1'b1;
    p.sx = rand_coord(span);
    p.sy = rand_coord(span);
    p.sz = rand_coord(span);
    p.tx = ($urandom_range(0, 1) == 0) ? p.sx + rand_coord(2) : rand_coord(span);
    p.ty = p.sy + rand_coord(2);
    p.tz = ($urandom_range(0, 4) == 0) ? rand_coord(0) : p.sz + rand_coord(2);
    p.last = last;
    return p;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_entries.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_kernel(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    kernel = value;
  endtask

  initial begin
    pair_req_t p;
    logic [31:0] kernels [6];
    int n;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_has_pair = 1'b0;
    in_last_pair = 1'b0;
    {in_src_x, in_src_y, in_src_z, in_tgt_x, in_tgt_y, in_tgt_z} = '0;
    out_stall = 1'b0;
    kernel = KernelReset;
    for (int k = 0; k < NumEntries; k++) begin
      sums[k] = 0;
      sat_marks[k] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: empty flush, idle request, extremes, saturation.
    pending_reqs.push_back('{1'b0, '0, '0, '0, '0, '0, '0, 1'b1});
    pending_reqs.push_back('{1'b0, '1, '1, '1, '1, '1, '1, 1'b0});
    pending_reqs.push_back('{1'b1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                             '0, '0, '0, 1'b1});
    pending_reqs.push_back('{1'b1, '0, '0, '0, '0, '0, '0, 1'b0});
    pending_reqs.push_back('{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back('{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFF0, 32'h8000_0010, 32'h8000_0000, i == 5});
    pending_reqs.push_back('{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0});
    pending_reqs.push_back('{1'b0, 32'h1234_5678, '0, '0, '0, '0, '0, 1'b1});
    wait_idle();

    kernels[0] = 32'hFFFF_FFFF;
    kernels[1] = 32'd1;
    kernels[2] = 32'd0;
    kernels[3] = 32'h0004_0000;
    kernels[4] = $urandom;
    kernels[5] = KernelReset;
    for (int phase = 0; phase < 6; phase++) begin
      write_kernel(kernels[phase]);
      stall_mode = phase % 2;
      n = 0;
      while (n < 50) begin
        int set_len;
        set_len = $urandom_range(1, 5);
        for (int j = 0; j < set_len; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            p = random_pair(1'b0);
            p.has_pair = 1'b0;
            p.last = (j == set_len - 1);
          end else begin
            p = random_pair(j == set_len - 1);
            n++;
          end
          pending_reqs.push_back(p);
        end
      end
      wait_idle();
    end

    $display("Covered %0d point pairs over %0d sets, %0d entries compared.",
             pairs_done, sets_done, entries_seen);
    $display("Kernel settings ranged from zero to full scale.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/icpne_pkg.sv
hw/rtl/icpne_front.sv
hw/rtl/icpne_queue.sv
hw/rtl/icpne_back.sv
hw/rtl/icp_normal_equation_accumulator.sv
dv/tb_top.sv
